// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the cache RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gtlc_pkg.sv =====
// Shared types and constants of the LRU result cache.
// No dependencies; used by the core, front and back modules.
`timescale 1ns / 1ps
package gtlc_pkg;
    localparam int DEF_ENTRIES  = 64;
    localparam int DEF_KEY_BITS = 64;

    localparam int KEY_W   = 64;
    localparam int ACT_W   = 8;
    localparam int GEN_W   = 32;
    localparam int STAMP_W = 64;
    localparam int SLOT_W  = 6;
    localparam int OP_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GEN    = 2'd1;

    typedef struct packed {
        logic              lookup;
        logic              store;
        logic              clear;
        logic [KEY_W-1:0]  key;
        logic [ACT_W-1:0]  action;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic [ACT_W-1:0]  action;
        logic [SLOT_W-1:0] slot;
    } t_result;
endpackage

// ===== rtl/generation_tagged_lru_result_cache_core.sv =====
// The back end takes a new request only after its result for the last one is
// queued. Lookups and stores with caching on scan every entry over the
// single RAM read port (one entry per cycle); clear, bypass and unused codes
// skip the scan.
// Reset (synchronous, active low): caching on, generation 0, all entries
// invalid, use clock zero, both queues empty. No clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module generation_tagged_lru_result_cache_core #(
    parameter int ENTRIES  = gtlc_pkg::DEF_ENTRIES,
    parameter int KEY_BITS = gtlc_pkg::DEF_KEY_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request side
    input  logic                             push,
    output logic                             full,
    input  logic [gtlc_pkg::OP_W-1:0]        i_operation,
    input  logic [gtlc_pkg::KEY_W-1:0]       i_key,
    input  logic [gtlc_pkg::ACT_W-1:0]       i_store_action,
    // result side
    output logic                             empty,
    input  logic                             pop,
    output logic                             o_hit,
    output logic [gtlc_pkg::ACT_W-1:0]       o_found_action,
    output logic [gtlc_pkg::SLOT_W-1:0]      o_slot,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [gtlc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gtlc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    // config registers
    logic                       r_enable;
    logic [gtlc_pkg::GEN_W-1:0] r_generation;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b1;
            r_generation <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gtlc_pkg::CFG_ENABLE: r_enable     <= i_cfg_data[0];
                gtlc_pkg::CFG_GEN:    r_generation <= i_cfg_data[gtlc_pkg::GEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front: decode and queue requests
    gtlc_pkg::t_req    req;
    logic              req_empty;
    logic              req_pop;

    gtlc_front #(.KEY_BITS(KEY_BITS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_operation    (i_operation),
        .i_key          (i_key),
        .i_store_action (i_store_action),
        .i_pop          (req_pop),
        .o_req          (req),
        .o_empty        (req_empty)
    );

    // back: scan, decide, write back, emit one result word per request
    gtlc_pkg::t_result res;
    logic              res_push;
    logic              res_full;

    gtlc_back #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req),
        .i_req_avail  (!req_empty),
        .o_req_pop    (req_pop),
        .i_enable     (r_enable),
        .i_generation (r_generation),
        .o_res        (res),
        .o_res_push   (res_push),
        .i_res_full   (res_full)
    );

    // result queue decouples the back end from the consumer
    logic [$bits(gtlc_pkg::t_result)-1:0] res_out;
    gtlc_pkg::t_result                    res_head;

    gtlc_fifo #(.W($bits(gtlc_pkg::t_result))) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign res_head       = gtlc_pkg::t_result'(res_out);
    assign o_hit          = res_head.hit;
    assign o_found_action = res_head.action;
    assign o_slot         = res_head.slot;

    `ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, res_push, !res_full, "result pushed while full")
    `ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, req_pop, !req_empty, "request popped while empty")
    `ASSERT_NEXT(a_push_shows, i_clk, i_rst_n, res_push, !empty, "result lost after push")
endmodule

// ===== rtl/gtlc_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module gtlc_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/gtlc_fifo.sv =====
// Two-word queue with registered storage.
// No dependencies.
`timescale 1ns / 1ps
module gtlc_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    logic [W-1:0] r_mem [2];
    logic         r_wr;
    logic         r_rd;
    logic [1:0]   r_cnt;
    logic         do_push;
    logic         do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule

// ===== rtl/gtlc_front.sv =====
// Front end: decodes the operation, masks the key, queues the request.
// Depends on gtlc_pkg and gtlc_fifo.
`timescale 1ns / 1ps
module gtlc_front #(
    parameter int KEY_BITS = gtlc_pkg::DEF_KEY_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [gtlc_pkg::OP_W-1:0]   i_operation,
    input  logic [gtlc_pkg::KEY_W-1:0]  i_key,
    input  logic [gtlc_pkg::ACT_W-1:0]  i_store_action,
    input  logic                        i_pop,
    output gtlc_pkg::t_req              o_req,
    output logic                        o_empty
);
    localparam logic [gtlc_pkg::KEY_W-1:0] KEY_MASK =
        (gtlc_pkg::KEY_W'(1) << KEY_BITS) - gtlc_pkg::KEY_W'(1);

    gtlc_pkg::t_req req;
    logic [$bits(gtlc_pkg::t_req)-1:0] q_out;

    always_comb begin
        req.lookup = (i_operation == gtlc_pkg::OP_LOOKUP);
        req.store  = (i_operation == gtlc_pkg::OP_STORE);
        req.clear  = (i_operation == gtlc_pkg::OP_CLEAR);
        req.key    = i_key & KEY_MASK;
        req.action = i_store_action;
    end

    gtlc_fifo #(.W($bits(gtlc_pkg::t_req))) u_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (req),
        .o_full  (full),
        .i_pop   (i_pop),
        .o_data  (q_out),
        .o_empty (o_empty)
    );

    assign o_req = gtlc_pkg::t_req'(q_out);
endmodule

// ===== rtl/gtlc_back.sv =====
// Back end: scans the entry RAM, picks hit or victim, writes back.
// Depends on gtlc_pkg and gtlc_ram.
`timescale 1ns / 1ps
module gtlc_back #(
    parameter int ENTRIES  = gtlc_pkg::DEF_ENTRIES,
    parameter int KEY_BITS = gtlc_pkg::DEF_KEY_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  gtlc_pkg::t_req             i_req,
    input  logic                       i_req_avail,
    output logic                       o_req_pop,
    input  logic                       i_enable,
    input  logic [gtlc_pkg::GEN_W-1:0] i_generation,
    output gtlc_pkg::t_result          o_res,
    output logic                       o_res_push,
    input  logic                       i_res_full
);
    localparam int IW = $clog2(ENTRIES);
    localparam int GW = gtlc_pkg::GEN_W;
    localparam int SW = gtlc_pkg::STAMP_W;
    localparam int AW = gtlc_pkg::ACT_W;
    localparam int WW = GW + SW + AW + KEY_BITS;
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]          r_state;
    logic                r_lookup;
    logic                r_store;
    logic [KEY_BITS-1:0] r_key;
    logic [AW-1:0]       r_act;
    logic [IW-1:0]       r_addr;
    logic                r_issuing;
    logic                r_pv;
    logic [IW-1:0]       r_pidx;
    logic                r_found;
    logic [IW-1:0]       r_fidx;
    logic [AW-1:0]       r_fact;
    logic                r_inv;
    logic [IW-1:0]       r_inv_idx;
    logic                r_have_min;
    logic [IW-1:0]       r_min_idx;
    logic [SW-1:0]       r_min_stamp;
    logic [SW-1:0]       r_clock;
    logic [ENTRIES-1:0]  r_valid;

    logic [WW-1:0]       rdata;
    logic [GW-1:0]       rd_gen;
    logic [SW-1:0]       rd_stamp;
    logic [AW-1:0]       rd_act;
    logic [KEY_BITS-1:0] rd_key;
    logic                rd_valid;
    logic                rd_match;
    logic [SW-1:0]       clk_inc;
    logic                we;
    logic [IW-1:0]       widx;
    logic [WW-1:0]       wdata;
    logic [IW+gtlc_pkg::SLOT_W-1:0] slot_ext;
    logic                done_go;

    assign {rd_gen, rd_stamp, rd_act, rd_key} = rdata;
    assign rd_valid = r_valid[r_pidx];
    assign rd_match = rd_valid && (rd_gen == i_generation) && (rd_key == r_key);
    assign clk_inc  = r_clock + SW'(1);
    assign done_go  = (r_state == S_DONE) && !i_res_full;

    always_comb begin
        we    = 1'b0;
        widx  = r_fidx;
        wdata = {i_generation, clk_inc, r_fact, r_key};
        if (r_lookup && r_found) begin
            we = done_go;
        end else if (r_store) begin
            we    = done_go;
            widx  = r_inv ? r_inv_idx : r_min_idx;
            wdata = {i_generation, clk_inc, r_act, r_key};
        end
    end

    assign slot_ext       = {{gtlc_pkg::SLOT_W{1'b0}}, widx};
    assign o_res.hit      = r_lookup && r_found;
    assign o_res.action   = (r_lookup && r_found) ? r_fact : '0;
    assign o_res.slot     = ((r_lookup && r_found) || r_store) ?
                            slot_ext[gtlc_pkg::SLOT_W-1:0] : '0;
    assign o_res_push     = done_go;
    assign o_req_pop      = (r_state == S_IDLE) && i_req_avail;

    gtlc_ram #(.W(WW), .DEPTH(ENTRIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (widx),
        .i_wdata (wdata),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_issuing <= 1'b0;
            r_pv      <= 1'b0;
            r_clock   <= '0;
            r_valid   <= '0;
            r_lookup  <= 1'b0;
            r_store   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req_avail) begin
                        r_lookup   <= i_req.lookup && i_enable;
                        r_store    <= i_req.store && i_enable;
                        r_key      <= i_req.key[KEY_BITS-1:0];
                        r_act      <= i_req.action;
                        r_addr     <= '0;
                        r_found    <= 1'b0;
                        r_inv      <= 1'b0;
                        r_have_min <= 1'b0;
                        if (i_req.clear) begin
                            r_valid <= '0;
                            r_clock <= '0;
                        end
                        if ((i_req.lookup || i_req.store) && i_enable) begin
                            r_state   <= S_SCAN;
                            r_issuing <= 1'b1;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCAN: begin
                    r_pv   <= r_issuing;
                    r_pidx <= r_addr;
                    if (r_issuing) begin
                        if (r_addr == LAST) begin
                            r_issuing <= 1'b0;
                        end else begin
                            r_addr <= r_addr + IW'(1);
                        end
                    end
                    if (r_pv) begin
                        if (rd_match && !r_found) begin
                            r_found <= 1'b1;
                            r_fidx  <= r_pidx;
                            r_fact  <= rd_act;
                        end
                        if (!rd_valid && !r_inv) begin
                            r_inv     <= 1'b1;
                            r_inv_idx <= r_pidx;
                        end
                        if (rd_valid && (!r_have_min || rd_stamp < r_min_stamp)) begin
                            r_have_min  <= 1'b1;
                            r_min_idx   <= r_pidx;
                            r_min_stamp <= rd_stamp;
                        end
                        if (r_pidx == LAST) begin
                            r_state <= S_DONE;
                            r_pv    <= 1'b0;
                        end
                    end
                end
                S_DONE: begin
                    if (!i_res_full) begin
                        r_state <= S_IDLE;
                        if (we) begin
                            r_clock <= clk_inc;
                        end
                        if (we && r_store) begin
                            r_valid[widx] <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule
